// ===== rtl/cip_pkg.sv =====
// shared types and constants for the column complex inner product block
// no dependencies; imported by every rtl file of the block
package cip_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int COL_W       = 4;
  localparam int CNT_W       = 5;
  localparam int DATA_W      = 16;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int TERM_W      = PROD_W + 1;
  localparam int ACC_W       = 48;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  // register index of active_columns
  localparam logic REG_ACTIVE_COLUMNS = 1'b0;

  typedef struct packed {
    logic [COL_W-1:0]         col;
    logic                     active;
    logic                     final_elem;
    logic signed [TERM_W-1:0] term_re;
    logic signed [TERM_W-1:0] term_im;
  } cip_item_t;

  typedef enum logic {
    BK_ACCUM,
    BK_DRAIN
  } back_state_t;

endpackage

// ===== rtl/cip_front.sv =====
// front end: accepts input beats, forms the four partial products and classifies
// the column; depends on cip_pkg
module cip_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [cip_pkg::DATA_W-1:0] in_x_real,
  input  logic signed [cip_pkg::DATA_W-1:0] in_x_imag,
  input  logic signed [cip_pkg::DATA_W-1:0] in_y_real,
  input  logic signed [cip_pkg::DATA_W-1:0] in_y_imag,
  input  logic [cip_pkg::COL_W-1:0]      in_column,
  input  logic                           in_final_element,
  input  logic [cip_pkg::CNT_W-1:0]      eff_cols,
  input  logic                           q_full,
  output logic                           q_push,
  output cip_pkg::cip_item_t             q_item
);
  import cip_pkg::*;

  logic                     s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]         s1_col_r;
  logic                     s1_active_r;
  logic                     s1_final_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                     in_accept;

  assign in_ready  = !s1_valid_r || !q_full;
  assign in_accept = in_valid && in_ready;
  assign q_push    = s1_valid_r && !q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r    <= in_column;
      s1_final_r  <= in_final_element;
      s1_active_r <= ({1'b0, in_column} < eff_cols);
      p_rr_r      <= in_x_real * in_y_real;
      p_ii_r      <= in_x_imag * in_y_imag;
      p_ri_r      <= in_x_real * in_y_imag;
      p_ir_r      <= in_x_imag * in_y_real;
    end
  end

  // conjugated product conj(x) * y
  always_comb begin
    q_item.col        = s1_col_r;
    q_item.active     = s1_active_r;
    q_item.final_elem = s1_final_r;
    q_item.term_re    = TERM_W'(p_rr_r) + TERM_W'(p_ii_r);
    q_item.term_im    = TERM_W'(p_ri_r) - TERM_W'(p_ir_r);
  end

endmodule

// ===== rtl/cip_queue.sv =====
// short fifo of classified items between the front end and the accumulator
// depends on cip_pkg
module cip_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cip_pkg::cip_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               pop_valid,
  output cip_pkg::cip_item_t pop_item
);
  import cip_pkg::*;

  cip_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/cip_back.sv =====
// back end: per-column saturating accumulators and the result drain sequencer
// depends on cip_pkg
module cip_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  cip_pkg::cip_item_t                  q_item,
  output logic                                q_pop,
  input  logic [cip_pkg::CNT_W-1:0]           eff_cols,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cip_pkg::COL_W-1:0]           out_result_column,
  output logic signed [cip_pkg::ACC_W-1:0]    out_sum_real,
  output logic signed [cip_pkg::ACC_W-1:0]    out_sum_imag,
  output logic                                out_last_result
);
  import cip_pkg::*;

  back_state_t            state_r, state_nxt;
  logic [COL_W-1:0]       drain_cnt_r, drain_cnt_nxt;
  logic signed [ACC_W-1:0] acc_re_r [MAX_COLUMNS];
  logic signed [ACC_W-1:0] acc_im_r [MAX_COLUMNS];
  logic signed [ACC_W-1:0] upd_re, upd_im;
  logic                   out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]       out_col_r;
  logic signed [ACC_W-1:0] out_re_r, out_im_r;
  logic                   out_last_r;
  logic                   out_load;
  logic                   drain_last;
  logic                   clear_all;
  logic [COL_W-1:0]       last_col;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [TERM_W-1:0] inc
  );
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(acc) + (ACC_W+1)'(inc);
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = {s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  assign last_col   = COL_W'(eff_cols - 1'b1);
  assign drain_last = (drain_cnt_r == last_col);

  // output block
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_ACCUM: q_pop    = q_valid;
      BK_DRAIN: out_load = !out_valid_r || out_ready;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign clear_all = out_load && drain_last;

  // next state
  always_comb begin
    state_nxt     = state_r;
    drain_cnt_nxt = drain_cnt_r;
    case (state_r)
      BK_ACCUM: begin
        if (q_pop && q_item.final_elem) begin
          state_nxt     = BK_DRAIN;
          drain_cnt_nxt = '0;
        end
      end
      BK_DRAIN: begin
        if (out_load) begin
          drain_cnt_nxt = drain_cnt_r + 1'b1;
          if (drain_last) begin
            state_nxt = BK_ACCUM;
          end
        end
      end
      default: state_nxt = BK_ACCUM;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign upd_re = sat_add(acc_re_r[q_item.col], q_item.term_re);
  assign upd_im = sat_add(acc_im_r[q_item.col], q_item.term_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_ACCUM;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // accumulators are cleared by reset and after the last result of a run
  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        acc_re_r[i] <= '0;
        acc_im_r[i] <= '0;
      end
    end else if (q_pop && q_item.active) begin
      acc_re_r[q_item.col] <= upd_re;
      acc_im_r[q_item.col] <= upd_im;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_col_r  <= drain_cnt_r;
      out_re_r   <= acc_re_r[drain_cnt_r];
      out_im_r   <= acc_im_r[drain_cnt_r];
      out_last_r <= drain_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_column = out_col_r;
  assign out_sum_real      = out_re_r;
  assign out_sum_imag      = out_im_r;
  assign out_last_result   = out_last_r;

endmodule

// ===== rtl/column_complex_inner_product.sv =====
// column complex inner product: front end, item queue and accumulator back end
// depends on cip_pkg, cip_front, cip_queue, cip_back
// throughput: one element per cycle while the queue is not full; the queue is not popped while a run is drained
// the first result of a run follows the final element through the front-end register, the queue,
// the drain state and the output register, later while the queue still holds earlier elements
// results then leave one per cycle while out_ready is high, from the drain counter
// reset: synchronous active-low rst_n clears accumulators, queue and active_columns to 1
module column_complex_inner_product (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cip_pkg::APB_AW-1:0]          cfg_paddr,
  input  logic [cip_pkg::APB_DW-1:0]          cfg_pwdata,
  output logic [cip_pkg::APB_DW-1:0]          cfg_prdata,
  output logic                                cfg_pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cip_pkg::DATA_W-1:0]   in_x_real,
  input  logic signed [cip_pkg::DATA_W-1:0]   in_x_imag,
  input  logic signed [cip_pkg::DATA_W-1:0]   in_y_real,
  input  logic signed [cip_pkg::DATA_W-1:0]   in_y_imag,
  input  logic [cip_pkg::COL_W-1:0]           in_column,
  input  logic                                in_final_element,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cip_pkg::COL_W-1:0]           out_result_column,
  output logic signed [cip_pkg::ACC_W-1:0]    out_sum_real,
  output logic signed [cip_pkg::ACC_W-1:0]    out_sum_imag,
  output logic                                out_last_result
);
  import cip_pkg::*;

  logic [CNT_W-1:0] active_cols_r, active_cols_nxt;
  logic [CNT_W-1:0] eff_cols;
  logic             reg_sel;
  logic             cfg_write;
  logic             q_full, q_push, q_pop, q_valid;
  cip_item_t        push_item, pop_item;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[APB_AW-1] == REG_ACTIVE_COLUMNS);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    active_cols_nxt = active_cols_r;
    if (cfg_write && reg_sel) begin
      active_cols_nxt = cfg_pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_cols_r <= CNT_W'(1);
    end else begin
      active_cols_r <= active_cols_nxt;
    end
  end

  assign cfg_prdata = reg_sel ? APB_DW'(active_cols_r) : '0;

  // zero acts as one, anything above the column count acts as the column count
  always_comb begin
    if (active_cols_r == '0) begin
      eff_cols = CNT_W'(1);
    end else if (active_cols_r > CNT_W'(MAX_COLUMNS)) begin
      eff_cols = CNT_W'(MAX_COLUMNS);
    end else begin
      eff_cols = active_cols_r;
    end
  end

  cip_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_x_real        (in_x_real),
    .in_x_imag        (in_x_imag),
    .in_y_real        (in_y_real),
    .in_y_imag        (in_y_imag),
    .in_column        (in_column),
    .in_final_element (in_final_element),
    .eff_cols         (eff_cols),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  cip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  cip_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (pop_item),
    .q_pop             (q_pop),
    .eff_cols          (eff_cols),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_column (out_result_column),
    .out_sum_real      (out_sum_real),
    .out_sum_imag      (out_sum_imag),
    .out_last_result   (out_last_result)
  );

endmodule

// ===== rtl/cip_checker.sv =====
// port-level checks for column_complex_inner_product, bound to the top level
// depends on cip_pkg
module cip_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [cip_pkg::COL_W-1:0]        out_result_column,
  input  logic signed [cip_pkg::ACC_W-1:0] out_sum_real,
  input  logic signed [cip_pkg::ACC_W-1:0] out_sum_imag,
  input  logic                             out_last_result
);
  import cip_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_column) &&
      $stable(out_sum_real) && $stable(out_sum_imag) && $stable(out_last_result))
    else $error("result beat changed while stalled");

  // results of a run follow each other with no gap and rising column
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=>
      out_valid && out_result_column == COL_W'($past(out_result_column) + 1'b1))
    else $error("result column sequence broken");

  // the highest column is always the last of a run
  a_top_col_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_column == COL_W'(MAX_COLUMNS - 1) |-> out_last_result)
    else $error("top column not marked last");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind column_complex_inner_product cip_checker u_cip_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_result_column (out_result_column),
  .out_sum_real      (out_sum_real),
  .out_sum_imag      (out_sum_imag),
  .out_last_result   (out_last_result)
);
